@@ design/signed_int_to_decimal_ascii_unit_assert.svh @@
// Assertion macros used by the top-level RTL.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SITDA_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define SITDA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle check");

`endif

@@ design/sitda_pkg.sv @@
package sitda_pkg;

   localparam int VALUE_BITS = 32;
   localparam int MAX_DIGITS = 10;

   localparam int BCD_BITS = 4 * MAX_DIGITS;
   localparam int CNT_W    = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
   localparam int LEFT_W   = $clog2(MAX_DIGITS + 1);
   localparam int CHAR_W   = 6;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

   // Converted number handed from the converter to the emitter.
   typedef struct packed {
      logic                valid;
      logic                neg;
      logic [BCD_BITS-1:0] bcd;
   } handoff_type;

endpackage

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// Signed integer to decimal ASCII text.
// Input channel req_ (valid/ready) carries one signed VALUE_BITS-bit integer.
// Result channel rsp_ (valid/ready) carries its text one character per
// transfer, most significant digit first: '-' for a negative value, then the
// digits without leading zeros (zero gives "0"); rsp_last marks the final one.
// An accepted number goes through the bit-serial BCD converter, one magnitude
// bit per cycle, and is then handed off to the emitter. The emitter skips the
// leading zeros one digit at a time and then shifts the characters into the
// output register; once the first is there, later ones follow one per cycle
// when the receiver keeps up. Converter and emitter overlap, so when the
// receiver keeps up the bit-serial shift sets the sustained throughput.
// Reset (synchronous, active high) empties both stages and the output register.
// When the receiver stalls, the output register holds its character and the
// emitter waits; the converter finishes and holds its result, and req_ready
// stays low until the emitter takes it.
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [sitda_pkg::CHAR_W-1:0]            rsp_char_code,
   output logic                                    rsp_last
);
   import sitda_pkg::*;

   handoff_type hand;
   logic        hand_ready;

   sitda_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .hand       (hand),
      .hand_ready (hand_ready)
   );

   sitda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .hand          (hand),
      .hand_ready    (hand_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   `SITDA_ASSERT_NOW(a_char_range, clock, reset, rsp_valid,
      rsp_char_code == CHAR_MINUS || (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE))
   `SITDA_ASSERT_NOW(a_sign_not_last, clock, reset,
      rsp_valid && rsp_char_code == CHAR_MINUS, !rsp_last)
   `SITDA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `SITDA_ASSERT_NEXT(a_handoff_clears, clock, reset, hand.valid && hand_ready, !hand.valid)

endmodule

@@ design/sitda_dabble.sv @@
// Bit-serial binary to BCD (shift and add-3), one magnitude bit per cycle.
module sitda_dabble (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [sitda_pkg::VALUE_BITS-1:0] req_value,
   output sitda_pkg::handoff_type              hand,
   input  logic                                hand_ready
);
   import sitda_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic                  accept;

   assign req_ready = !busy_ff && !done_ff;
   assign accept    = req_valid && req_ready;
   assign raw       = req_value;
   assign mag       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

   always_comb begin
      logic [3:0] dig;
      dig = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dig = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (accept) begin
         busy_in = 1'b1;
         neg_in  = raw[VALUE_BITS-1];
         cnt_in  = CNT_W'(VALUE_BITS - 1);
         bin_in  = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         // carry out of the top digit drops: result is magnitude mod 10^MAX_DIGITS
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && hand_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign hand.valid = done_ff;
   assign hand.neg   = neg_ff;
   assign hand.bcd   = bcd_ff;

endmodule

@@ design/sitda_emit.sv @@
// Emits '-' for a negative value, then BCD digits MSD first, skipping leading zeros, into an output register.
module sitda_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  sitda_pkg::handoff_type           hand,
   output logic                             hand_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sitda_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                             rsp_last
);
   import sitda_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SKIP  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } emit_state_type;

   emit_state_type        state_ff, state_in;
   logic [BCD_BITS-1:0]   dig_ff, dig_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic                  neg_ff, neg_in;
   logic                  valid_ff, valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;
   logic [3:0]            top_dig;
   logic                  slot_free;
   logic                  push;

   assign top_dig    = dig_ff[BCD_BITS-1 -: 4];
   assign slot_free  = !valid_ff || rsp_ready;
   assign hand_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      push     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (hand.valid) begin
               dig_in   = hand.bcd;
               neg_in   = hand.neg;
               left_in  = LEFT_W'(MAX_DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_dig == 4'd0 && left_ff > LEFT_W'(1)) begin
               dig_in  = {dig_ff[BCD_BITS-5:0], 4'd0};
               left_in = left_ff - LEFT_W'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               push     = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               push    = 1'b1;
               char_in = CHAR_ZERO + {2'b00, top_dig};
               last_in = (left_ff == LEFT_W'(1));
               dig_in  = {dig_ff[BCD_BITS-5:0], 4'd0};
               left_in = left_ff - LEFT_W'(1);
               if (left_ff == LEFT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      dig_ff  <= dig_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule
